// ----- src/bis_pkg.sv -----
package bis_pkg;

   localparam int MAX_IN_WIDTH  = 256;
   localparam int MAX_IN_HEIGHT = 256;
   localparam int MAX_OUT_DIM   = 4096;
   localparam int CHANNELS      = 3;

   localparam int POS_BITS  = 12;
   localparam int CHAN_BITS = 8;
   localparam int PIX_BITS  = CHANNELS * CHAN_BITS;
   localparam int CSR_BITS  = 13;
   localparam int IDX_BITS  = 2;

   // saturated dimension widths
   localparam int IW_BITS = $clog2(MAX_IN_WIDTH + 1);
   localparam int IH_BITS = $clog2(MAX_IN_HEIGHT + 1);
   localparam int OD_BITS = $clog2(MAX_OUT_DIM + 1);

   localparam int ROW_BITS = ($clog2(MAX_IN_HEIGHT) < 2) ? 2 : $clog2(MAX_IN_HEIGHT);
   localparam int COL_BITS = ($clog2(MAX_IN_WIDTH) < 2) ? 2 : $clog2(MAX_IN_WIDTH);

   // quotient bits per divider: covers both pixel values and source indices
   localparam int QB_RC   = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
   localparam int QB      = (QB_RC > CHAN_BITS) ? QB_RC : CHAN_BITS;
   localparam int DVW     = QB + OD_BITS;

   localparam int BANK_ADDR_BITS = ROW_BITS + COL_BITS - 2;
   localparam int BANK_DEPTH     = 2 ** BANK_ADDR_BITS;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic [IDX_BITS-1:0] CSR_IN_WIDTH   = 2'd0;
   localparam logic [IDX_BITS-1:0] CSR_IN_HEIGHT  = 2'd1;
   localparam logic [IDX_BITS-1:0] CSR_OUT_WIDTH  = 2'd2;
   localparam logic [IDX_BITS-1:0] CSR_OUT_HEIGHT = 2'd3;

   typedef struct packed {
      logic                 operation;
      logic [POS_BITS-1:0]  row;
      logic [POS_BITS-1:0]  col;
      logic [CHAN_BITS-1:0] red_in;
      logic [CHAN_BITS-1:0] green_in;
      logic [CHAN_BITS-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red_out;
      logic [CHAN_BITS-1:0] green_out;
      logic [CHAN_BITS-1:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic                 wr;
      logic [ROW_BITS-1:0]  wr_row;
      logic [COL_BITS-1:0]  wr_col;
      logic [PIX_BITS-1:0]  wr_pixel;
      logic [ROW_BITS-1:0]  rd_r0;
      logic [ROW_BITS-1:0]  rd_r1;
      logic [COL_BITS-1:0]  rd_c0;
      logic [COL_BITS-1:0]  rd_c1;
   } store_req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] p00;
      logic [PIX_BITS-1:0] p10;
      logic [PIX_BITS-1:0] p01;
      logic [PIX_BITS-1:0] p11;
   } quad_type;

   // 0 reads as 1, anything above the maximum reads as the maximum
   function automatic logic [15:0] sat_dim(input logic [15:0] v, input int maxv);
      logic [15:0] r;
      if (v == 16'd0) begin
         r = 16'd1;
      end else if (int'(v) > maxv) begin
         r = 16'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- src/bis_divider.sv -----
// Restoring divider, one quotient bit per stage. The user must hold the divisor static; the block does not enforce it.
module bis_divider (
   input  logic                        clock,
   input  logic                        en,
   input  logic [bis_pkg::DVW-1:0]     dividend,
   input  logic [bis_pkg::OD_BITS-1:0] divisor,
   output logic [bis_pkg::QB-1:0]      quotient,
   output logic [bis_pkg::OD_BITS-1:0] remainder
);

   logic [bis_pkg::DVW-1:0] rem_ff [bis_pkg::QB];
   logic [bis_pkg::QB-1:0]  quo_ff [bis_pkg::QB];

   for (genvar i = 0; i < bis_pkg::QB; i++) begin : g_stage
      logic [bis_pkg::DVW-1:0] rem_prev;
      logic [bis_pkg::QB-1:0]  quo_prev;
      logic [bis_pkg::DVW-1:0] trial;
      logic [bis_pkg::DVW-1:0] rem_in;
      logic [bis_pkg::QB-1:0]  quo_in;
      logic                    ge;

      if (i == 0) begin : g_first
         assign rem_prev = dividend;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign trial = bis_pkg::DVW'(divisor) << (bis_pkg::QB - 1 - i);
      assign ge    = (rem_prev >= trial);

      always_comb begin
         rem_in = ge ? (rem_prev - trial) : rem_prev;
         quo_in = quo_prev;
         quo_in[bis_pkg::QB-1-i] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign quotient  = quo_ff[bis_pkg::QB-1];
   assign remainder = rem_ff[bis_pkg::QB-1][bis_pkg::OD_BITS-1:0];

endmodule

// ----- src/bis_frame_store.sv -----
// Four banks split by row and column parity; the 2x2 neighborhood always
// hits each bank at most once.
module bis_frame_store (
   input  logic                   clock,
   input  logic                   en,
   input  bis_pkg::store_req_type req,
   output bis_pkg::quad_type      quad
);

   logic [bis_pkg::PIX_BITS-1:0] bank_q [4];
   logic sel_r0_ff, sel_r1_ff, sel_c0_ff, sel_c1_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic RP = 1'(b / 2);
      localparam logic CP = 1'(b % 2);

      logic [bis_pkg::PIX_BITS-1:0]       mem_ff [bis_pkg::BANK_DEPTH];
      logic [bis_pkg::PIX_BITS-1:0]       rd_ff;
      logic [bis_pkg::ROW_BITS-1:0]       rrow;
      logic [bis_pkg::COL_BITS-1:0]       rcol;
      logic [bis_pkg::BANK_ADDR_BITS-1:0] raddr;
      logic [bis_pkg::BANK_ADDR_BITS-1:0] waddr;

      assign rrow  = (req.rd_r0[0] == RP) ? req.rd_r0 : req.rd_r1;
      assign rcol  = (req.rd_c0[0] == CP) ? req.rd_c0 : req.rd_c1;
      assign raddr = {rrow[bis_pkg::ROW_BITS-1:1], rcol[bis_pkg::COL_BITS-1:1]};
      assign waddr = {req.wr_row[bis_pkg::ROW_BITS-1:1], req.wr_col[bis_pkg::COL_BITS-1:1]};

      always_ff @(posedge clock) begin
         if (en) begin
            if (req.wr && req.wr_row[0] == RP && req.wr_col[0] == CP) begin
               mem_ff[waddr] <= req.wr_pixel;
            end
            rd_ff <= mem_ff[raddr];
         end
      end

      assign bank_q[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel_r0_ff <= req.rd_r0[0];
         sel_r1_ff <= req.rd_r1[0];
         sel_c0_ff <= req.rd_c0[0];
         sel_c1_ff <= req.rd_c1[0];
      end
   end

   assign quad.p00 = bank_q[{sel_r0_ff, sel_c0_ff}];
   assign quad.p10 = bank_q[{sel_r1_ff, sel_c0_ff}];
   assign quad.p01 = bank_q[{sel_r0_ff, sel_c1_ff}];
   assign quad.p11 = bank_q[{sel_r1_ff, sel_c1_ff}];

endmodule

// ----- src/bilinear_rgb_image_scaler.sv -----
// Throughput: one item per cycle while the output queue has room; set by the
// one-bit-per-stage dividers and the frame store's four parity banks, one read each per cycle.
// A two-entry output queue keeps input flowing while a result waits.
// Reset (synchronous) empties the pipeline and queue and sets all sizes to 256;
// the frame store is not cleared.
module bilinear_rgb_image_scaler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bis_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bis_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [bis_pkg::IDX_BITS-1:0]     csr_index,
   input  logic [bis_pkg::CSR_BITS-1:0]     csr_write_data
);

   localparam int QB   = bis_pkg::QB;
   localparam int DVW  = bis_pkg::DVW;
   localparam int ODB  = bis_pkg::OD_BITS;
   localparam int RB   = bis_pkg::ROW_BITS;
   localparam int CB   = bis_pkg::COL_BITS;
   localparam int CHB  = bis_pkg::CHAN_BITS;
   localparam int CMPW = bis_pkg::POS_BITS + ODB;

   typedef struct packed {
      logic                           op;
      logic [bis_pkg::POS_BITS-1:0]   row;
      logic [bis_pkg::POS_BITS-1:0]   col;
      logic [bis_pkg::PIX_BITS-1:0]   pixel;
      logic                           rclamp;
      logic                           cclamp;
   } item_type;

   // saturated sizes
   logic [bis_pkg::IW_BITS-1:0] iw_ff;
   logic [bis_pkg::IH_BITS-1:0] ih_ff;
   logic [ODB-1:0]              ow_ff;
   logic [ODB-1:0]              oh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= bis_pkg::IW_BITS'(bis_pkg::sat_dim(16'd256, bis_pkg::MAX_IN_WIDTH));
         ih_ff <= bis_pkg::IH_BITS'(bis_pkg::sat_dim(16'd256, bis_pkg::MAX_IN_HEIGHT));
         ow_ff <= ODB'(bis_pkg::sat_dim(16'd256, bis_pkg::MAX_OUT_DIM));
         oh_ff <= ODB'(bis_pkg::sat_dim(16'd256, bis_pkg::MAX_OUT_DIM));
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bis_pkg::CSR_IN_WIDTH: begin
               iw_ff <= bis_pkg::IW_BITS'(bis_pkg::sat_dim(16'(csr_write_data[8:0]),
                                                           bis_pkg::MAX_IN_WIDTH));
            end
            bis_pkg::CSR_IN_HEIGHT: begin
               ih_ff <= bis_pkg::IH_BITS'(bis_pkg::sat_dim(16'(csr_write_data[8:0]),
                                                           bis_pkg::MAX_IN_HEIGHT));
            end
            bis_pkg::CSR_OUT_WIDTH: begin
               ow_ff <= ODB'(bis_pkg::sat_dim(16'(csr_write_data), bis_pkg::MAX_OUT_DIM));
            end
            bis_pkg::CSR_OUT_HEIGHT: begin
               oh_ff <= ODB'(bis_pkg::sat_dim(16'(csr_write_data), bis_pkg::MAX_OUT_DIM));
            end
            default: begin
            end
         endcase
      end
   end

   logic en;
   logic [1:0] cnt_ff;
   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;

   logic accept;
   assign accept = req_valid && req_ready;

   // ---- stage 0: position products ----
   logic                                      s0_vld_ff;
   item_type                                  s0_ff;
   logic [DVW-1:0]                            rprod_ff, cprod_ff;
   logic [bis_pkg::POS_BITS+bis_pkg::IH_BITS-1:0] rprod;
   logic [bis_pkg::POS_BITS+bis_pkg::IW_BITS-1:0] cprod;
   item_type                                  s0_in;

   assign rprod = (bis_pkg::POS_BITS+bis_pkg::IH_BITS)'(req_payload.row) *
                  (bis_pkg::POS_BITS+bis_pkg::IH_BITS)'(ih_ff);
   assign cprod = (bis_pkg::POS_BITS+bis_pkg::IW_BITS)'(req_payload.col) *
                  (bis_pkg::POS_BITS+bis_pkg::IW_BITS)'(iw_ff);

   always_comb begin
      s0_in.op     = req_payload.operation;
      s0_in.row    = req_payload.row;
      s0_in.col    = req_payload.col;
      s0_in.pixel  = {req_payload.red_in, req_payload.green_in, req_payload.blue_in};
      // past the output image: both neighbors clamp to the last source line
      s0_in.rclamp = CMPW'(req_payload.row) >= CMPW'(oh_ff);
      s0_in.cclamp = CMPW'(req_payload.col) >= CMPW'(ow_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff    <= s0_in;
         rprod_ff <= DVW'(rprod);
         cprod_ff <= DVW'(cprod);
      end
   end

   // ---- source position divide ----
   logic [QB-1:0]  rq, cq;
   logic [ODB-1:0] rrem, crem;

   bis_divider u_row_map (
      .clock(clock), .en(en), .dividend(rprod_ff), .divisor(oh_ff),
      .quotient(rq), .remainder(rrem)
   );

   bis_divider u_col_map (
      .clock(clock), .en(en), .dividend(cprod_ff), .divisor(ow_ff),
      .quotient(cq), .remainder(crem)
   );

   logic     a_vld_ff [QB];
   item_type a_ff     [QB];

   // ---- neighbor indices and frame store access ----
   item_type                a_last;
   logic [RB-1:0]           ih_m1, r0, r1;
   logic [CB-1:0]           iw_m1, c0, c1;
   logic [ODB-1:0]          fr, fc;
   bis_pkg::store_req_type  sreq;
   bis_pkg::quad_type       quad;

   assign a_last = a_ff[QB-1];
   assign ih_m1  = RB'(ih_ff - 1'b1);
   assign iw_m1  = CB'(iw_ff - 1'b1);

   always_comb begin
      if (a_last.rclamp) begin
         r0 = ih_m1;
         r1 = ih_m1;
         fr = '0;
      end else begin
         r0 = rq[RB-1:0];
         r1 = (r0 == ih_m1) ? ih_m1 : RB'(r0 + 1'b1);
         fr = rrem;
      end
      if (a_last.cclamp) begin
         c0 = iw_m1;
         c1 = iw_m1;
         fc = '0;
      end else begin
         c0 = cq[CB-1:0];
         c1 = (c0 == iw_m1) ? iw_m1 : CB'(c0 + 1'b1);
         fc = crem;
      end
   end

   always_comb begin
      // loads beyond the store are dropped
      sreq.wr       = a_vld_ff[QB-1] && (a_last.op == bis_pkg::OP_LOAD) &&
                      (int'(a_last.row) < bis_pkg::MAX_IN_HEIGHT) &&
                      (int'(a_last.col) < bis_pkg::MAX_IN_WIDTH);
      sreq.wr_row   = a_last.row[RB-1:0];
      sreq.wr_col   = a_last.col[CB-1:0];
      sreq.wr_pixel = a_last.pixel;
      sreq.rd_r0    = r0;
      sreq.rd_r1    = r1;
      sreq.rd_c0    = c0;
      sreq.rd_c1    = c1;
   end

   bis_frame_store u_store (
      .clock(clock), .en(en), .req(sreq), .quad(quad)
   );

   logic           b_vld_ff, b_op_ff;
   logic [ODB-1:0] b_fr_ff, b_fc_ff;

   // ---- row interpolation dividends ----
   logic [DVW-1:0] rowdiv_in [2*bis_pkg::CHANNELS];
   logic [DVW-1:0] rowdiv_ff [2*bis_pkg::CHANNELS];
   logic           c_vld_ff, c_op_ff;
   logic [ODB-1:0] c_fc_ff;

   always_comb begin
      for (int k = 0; k < bis_pkg::CHANNELS; k++) begin
         rowdiv_in[k] =
            DVW'(quad.p00[CHB*(bis_pkg::CHANNELS-1-k) +: CHB]) * DVW'(oh_ff - b_fr_ff) +
            DVW'(quad.p10[CHB*(bis_pkg::CHANNELS-1-k) +: CHB]) * DVW'(b_fr_ff);
         rowdiv_in[bis_pkg::CHANNELS+k] =
            DVW'(quad.p01[CHB*(bis_pkg::CHANNELS-1-k) +: CHB]) * DVW'(oh_ff - b_fr_ff) +
            DVW'(quad.p11[CHB*(bis_pkg::CHANNELS-1-k) +: CHB]) * DVW'(b_fr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rowdiv_ff <= rowdiv_in;
      end
   end

   logic [CHB-1:0] row_lerp [2*bis_pkg::CHANNELS];

   for (genvar j = 0; j < 2*bis_pkg::CHANNELS; j++) begin : g_row_div
      logic [QB-1:0]  q;
      logic [ODB-1:0] rem_unused;
      bis_divider u_div (
         .clock(clock), .en(en), .dividend(rowdiv_ff[j]), .divisor(oh_ff),
         .quotient(q), .remainder(rem_unused)
      );
      assign row_lerp[j] = q[CHB-1:0];
   end

   logic           bl_vld_ff [QB];
   logic           bl_op_ff  [QB];
   logic [ODB-1:0] bl_fc_ff  [QB];

   // ---- column interpolation dividends ----
   logic [DVW-1:0] coldiv_in [bis_pkg::CHANNELS];
   logic [DVW-1:0] coldiv_ff [bis_pkg::CHANNELS];
   logic           d_vld_ff, d_op_ff;
   logic [ODB-1:0] fc_b;

   assign fc_b = bl_fc_ff[QB-1];

   always_comb begin
      for (int k = 0; k < bis_pkg::CHANNELS; k++) begin
         coldiv_in[k] = DVW'(row_lerp[k]) * DVW'(ow_ff - fc_b) +
                        DVW'(row_lerp[bis_pkg::CHANNELS+k]) * DVW'(fc_b);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coldiv_ff <= coldiv_in;
      end
   end

   logic [CHB-1:0] col_lerp [bis_pkg::CHANNELS];

   for (genvar k = 0; k < bis_pkg::CHANNELS; k++) begin : g_col_div
      logic [QB-1:0]  q;
      logic [ODB-1:0] rem_unused;
      bis_divider u_div (
         .clock(clock), .en(en), .dividend(coldiv_ff[k]), .divisor(ow_ff),
         .quotient(q), .remainder(rem_unused)
      );
      assign col_lerp[k] = q[CHB-1:0];
   end

   logic cl_vld_ff [QB];
   logic cl_op_ff  [QB];

   // ---- pipeline payload ----
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]     <= s0_ff;
         bl_op_ff[0] <= c_op_ff;
         bl_fc_ff[0] <= c_fc_ff;
         cl_op_ff[0] <= d_op_ff;
         for (int i = 1; i < QB; i++) begin
            a_ff[i]     <= a_ff[i-1];
            bl_op_ff[i] <= bl_op_ff[i-1];
            bl_fc_ff[i] <= bl_fc_ff[i-1];
            cl_op_ff[i] <= cl_op_ff[i-1];
         end
         b_op_ff <= a_last.op;
         b_fr_ff <= fr;
         b_fc_ff <= fc;
         c_op_ff <= b_op_ff;
         c_fc_ff <= b_fc_ff;
         d_op_ff <= bl_op_ff[QB-1];
      end
   end

   // ---- pipeline valids ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
         for (int i = 0; i < QB; i++) begin
            a_vld_ff[i]  <= 1'b0;
            bl_vld_ff[i] <= 1'b0;
            cl_vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         s0_vld_ff    <= accept;
         a_vld_ff[0]  <= s0_vld_ff;
         bl_vld_ff[0] <= c_vld_ff;
         cl_vld_ff[0] <= d_vld_ff;
         for (int i = 1; i < QB; i++) begin
            a_vld_ff[i]  <= a_vld_ff[i-1];
            bl_vld_ff[i] <= bl_vld_ff[i-1];
            cl_vld_ff[i] <= cl_vld_ff[i-1];
         end
         b_vld_ff <= a_vld_ff[QB-1];
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= bl_vld_ff[QB-1];
      end
   end

   // ---- output queue ----
   bis_pkg::rsp_type ent_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic             push, pop;
   bis_pkg::rsp_type result;

   assign result.red_out   = col_lerp[0];
   assign result.green_out = col_lerp[1];
   assign result.blue_out  = col_lerp[2];

   assign push = en && cl_vld_ff[QB-1] && (cl_op_ff[QB-1] == bis_pkg::OP_COMPUTE);
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   assign rsp_valid   = (cnt_ff != 2'd0);
   assign rsp_payload = ent_ff[rd_ptr_ff];

endmodule

// ----- src/bis_checker.sv -----
module bis_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bis_pkg::rsp_type rsp_payload
);

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp_payload changed while stalled");

   // input only backs up once results are waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not empty after reset");

endmodule

bind bilinear_rgb_image_scaler bis_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);
